>>> sv/mbfr_pkg.sv
// Shared constants, codes and types of the MSB-first bit-field reader.
`timescale 1ns / 1ps
package mbfr_pkg;

   // Default sizes and fixed field widths.
   localparam int STORE_BITS_DEF = 128;
   localparam int MAX_FIELD_DEF  = 64;
   localparam int QUEUE_DEPTH    = 2;
   localparam int FIELD_BITS     = 64;
   localparam int MODE_W         = 2;
   localparam int BYTE_W         = 8;
   localparam int WIDTH_W        = 7;
   localparam int STATUS_W       = 2;
   localparam int HELD_W         = 8;

   // Input word modes.
   localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REQ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

   // Operations as queued for the back end.
   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_REQ  = 2'd1;
   localparam logic [1:0] OP_END  = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RAN_OUT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BUSY     = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [BYTE_W-1:0]  data_byte;
      logic [WIDTH_W-1:0] width;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } slot_type;

endpackage

>>> sv/mbfr_req_if.sv
// Request channel interface: input words with valid/ready handshake.
`timescale 1ns / 1ps
interface mbfr_req_if;
   import mbfr_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [BYTE_W-1:0]  data_byte;
   logic [WIDTH_W-1:0] field_width;

   modport source (output valid, mode, data_byte, field_width, input ready);
   modport sink (input valid, mode, data_byte, field_width, output ready);
endinterface

>>> sv/mbfr_rsp_if.sv
// Response channel interface: result words with valid/ready handshake.
`timescale 1ns / 1ps
interface mbfr_rsp_if;
   import mbfr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] field_value;
   logic [STATUS_W-1:0]   status;
   logic [HELD_W-1:0]     bits_held;
   logic                  stream_empty;

   modport source (output valid, field_value, status, bits_held, stream_empty, input ready);
   modport sink (input valid, field_value, status, bits_held, stream_empty, output ready);
endinterface

>>> sv/msb_first_bit_field_reader_unit.sv
// An accepted input word is held in the queue, and the result word it causes is then registered in the result register.
// Throughput: one input word per cycle while the queue has space and the result port is not stalled.
// A two-entry queue separates input acceptance from the back end and the result register.
// Reset (synchronous, active high) clears the bit count, pending request, end flag, result valid flag and queue.
// Accumulator contents are not reset; only bits below the bit count are ever read.
`timescale 1ns / 1ps
module msb_first_bit_field_reader_unit #(
   parameter int STORE_BITS = mbfr_pkg::STORE_BITS_DEF,
   parameter int MAX_FIELD  = mbfr_pkg::MAX_FIELD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mbfr_req_if.sink   req_port,
   mbfr_rsp_if.source rsp_port
);
   import mbfr_pkg::*;

   slot_type enq;
   slot_type head;
   logic     space_ok;
   logic     pop;

   // Classify incoming words.
   mbfr_front #(
      .MAX_FIELD (MAX_FIELD)
   ) u_front (
      .req_port (req_port),
      .space_ok (space_ok),
      .enq      (enq)
   );

   // Decouple the two ends.
   mbfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .enq      (enq),
      .space_ok (space_ok),
      .head     (head),
      .pop      (pop)
   );

   // Execute operations and hold results.
   mbfr_back #(
      .STORE_BITS (STORE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

endmodule

>>> sv/mbfr_front.sv
// Front end: accepts input words, clamps the width and decodes the mode.
`timescale 1ns / 1ps
module mbfr_front #(
   parameter int MAX_FIELD = mbfr_pkg::MAX_FIELD_DEF
) (
   mbfr_req_if.sink           req_port,
   input  logic               space_ok,
   output mbfr_pkg::slot_type enq
);
   import mbfr_pkg::*;

   logic [WIDTH_W-1:0] width_clamped;

   // Widths above the largest field are served as the largest field.
   assign width_clamped = (req_port.field_width > WIDTH_W'(MAX_FIELD)) ?
                          WIDTH_W'(MAX_FIELD) : req_port.field_width;

   assign req_port.ready = space_ok;

   // Map the mode onto a queued operation; the unused mode is accepted and dropped.
   always_comb begin
      enq               = '0;
      enq.cmd.data_byte = req_port.data_byte;
      enq.cmd.width     = width_clamped;
      case (req_port.mode)
         MODE_PUSH: begin
            enq.valid  = req_port.valid && space_ok;
            enq.cmd.op = OP_PUSH;
         end
         MODE_REQ: begin
            enq.valid  = req_port.valid && space_ok;
            enq.cmd.op = OP_REQ;
         end
         MODE_END: begin
            enq.valid  = req_port.valid && space_ok;
            enq.cmd.op = OP_END;
         end
         default: begin
            enq.valid  = 1'b0;
            enq.cmd.op = OP_PUSH;
         end
      endcase
   end

endmodule

>>> sv/mbfr_queue.sv
// Short first-in first-out queue between the front and back ends.
`timescale 1ns / 1ps
module mbfr_queue #(
   parameter int DEPTH = mbfr_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  mbfr_pkg::slot_type enq,
   output logic               space_ok,
   output mbfr_pkg::slot_type head,
   input  logic               pop
);
   import mbfr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign space_ok   = (fill_ff != CNT_W'(DEPTH));
   assign head.valid = (fill_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      if (enq.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq.valid && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!enq.valid && pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (enq.valid) begin
         entries_ff[wr_ptr_ff] <= enq.cmd;
      end
   end

endmodule

>>> sv/mbfr_back.sv
// Back end: bit accumulator, pending request, field extraction and result register.
`timescale 1ns / 1ps
module mbfr_back #(
   parameter int STORE_BITS = mbfr_pkg::STORE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  mbfr_pkg::slot_type head,
   output logic               pop,
   mbfr_rsp_if.source         rsp_port
);
   import mbfr_pkg::*;

   localparam int CW = $clog2(STORE_BITS + 1);

   logic [STORE_BITS-1:0] store_ff, store_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  pend_ff, pend_in;
   logic [WIDTH_W-1:0]    pend_w_ff, pend_w_in;
   logic                  end_ff, end_in;

   logic                  out_valid_ff;
   logic [FIELD_BITS-1:0] out_value_ff;
   logic [STATUS_W-1:0]   out_status_ff;
   logic [HELD_W-1:0]     out_held_ff;
   logic                  out_empty_ff;

   logic [STORE_BITS-1:0] appended;
   logic [CW-1:0]         app_count;
   logic                  fits;
   logic [STORE_BITS-1:0] ext_src;
   logic [CW-1:0]         ext_cnt;
   logic [WIDTH_W-1:0]    ext_w;
   logic [CW-1:0]         ext_shift;
   logic [STORE_BITS-1:0] ext_shifted;
   logic [FIELD_BITS-1:0] ext_mask;
   logic [FIELD_BITS-1:0] ext_value;
   logic                  res_fire;
   logic                  res_take;
   logic [STATUS_W-1:0]   res_status;

   // Take the next queued word whenever the result register is free or draining.
   assign pop = head.valid && (!out_valid_ff || rsp_port.ready);

   // The accumulator after a byte is appended at the low end.
   assign appended  = {store_ff[STORE_BITS-BYTE_W-1:0], head.cmd.data_byte};
   assign app_count = count_ff + CW'(BYTE_W);
   assign fits      = ({1'b0, count_ff} + (CW + 1)'(BYTE_W)) <= (CW + 1)'(STORE_BITS);

   // Field extraction: the oldest unread bit is the top of the low count bits.
   assign ext_shift   = ext_cnt - CW'(ext_w);
   assign ext_shifted = ext_src >> ext_shift;
   assign ext_mask    = ~({FIELD_BITS{1'b1}} << ext_w);
   assign ext_value   = ext_shifted[FIELD_BITS-1:0] & ext_mask;

   // Operation decode and next state.
   always_comb begin
      store_in   = store_ff;
      count_in   = count_ff;
      pend_in    = pend_ff;
      pend_w_in  = pend_w_ff;
      end_in     = end_ff;
      ext_src    = store_ff;
      ext_cnt    = count_ff;
      ext_w      = head.cmd.width;
      res_fire   = 1'b0;
      res_take   = 1'b0;
      res_status = STATUS_OK;
      if (pop) begin
         case (head.cmd.op)
            OP_PUSH: begin
               if (!fits) begin
                  res_fire   = 1'b1;
                  res_status = STATUS_OVERFLOW;
               end else begin
                  store_in = appended;
                  count_in = app_count;
                  ext_src  = appended;
                  ext_cnt  = app_count;
                  ext_w    = pend_w_ff;
                  if (pend_ff && (app_count >= CW'(pend_w_ff))) begin
                     res_fire  = 1'b1;
                     res_take  = 1'b1;
                     pend_in   = 1'b0;
                     pend_w_in = '0;
                     count_in  = app_count - CW'(pend_w_ff);
                  end
               end
            end
            OP_REQ: begin
               if (pend_ff) begin
                  res_fire   = 1'b1;
                  res_status = STATUS_BUSY;
               end else if (count_ff >= CW'(head.cmd.width)) begin
                  res_fire = 1'b1;
                  res_take = 1'b1;
                  count_in = count_ff - CW'(head.cmd.width);
               end else if (end_ff) begin
                  res_fire   = 1'b1;
                  res_status = STATUS_RAN_OUT;
               end else begin
                  pend_in   = 1'b1;
                  pend_w_in = head.cmd.width;
               end
            end
            OP_END: begin
               end_in = 1'b1;
               if (pend_ff) begin
                  res_fire   = 1'b1;
                  res_status = STATUS_RAN_OUT;
                  pend_in    = 1'b0;
                  pend_w_in  = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         pend_w_ff    <= '0;
         end_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         pend_w_ff <= pend_w_in;
         end_ff    <= end_in;
         if (pop && res_fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Accumulator bits and result payload carry no reset.
   always_ff @(posedge clock) begin
      store_ff <= store_in;
      if (pop && res_fire) begin
         out_value_ff  <= res_take ? ext_value : '0;
         out_status_ff <= res_status;
         out_held_ff   <= HELD_W'(count_in);
         out_empty_ff  <= end_in && (count_in == '0);
      end
   end

   assign rsp_port.valid        = out_valid_ff;
   assign rsp_port.field_value  = out_value_ff;
   assign rsp_port.status       = out_status_ff;
   assign rsp_port.bits_held    = out_held_ff;
   assign rsp_port.stream_empty = out_empty_ff;

endmodule

>>> sv/mbfr_checker.sv
// Port-level checks of the bit-field reader, bound to the top level.
`timescale 1ns / 1ps
module mbfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_field_value,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_bits_held,
   input logic        rsp_stream_empty
);
   import mbfr_pkg::*;

   // A stalled result word keeps its value, status and bit count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_field_value) &&
                                     $stable(rsp_status) && $stable(rsp_bits_held)))
      else $error("result word changed while stalled");

   // Every error status carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (rsp_field_value == '0))
      else $error("non-zero value on an error status");

   // An empty stream holds no bits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_empty) |-> (rsp_bits_held == '0))
      else $error("empty flag with bits still held");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

endmodule

bind msb_first_bit_field_reader_unit mbfr_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_field_value  (rsp_port.field_value),
   .rsp_status       (rsp_port.status),
   .rsp_bits_held    (rsp_port.bits_held),
   .rsp_stream_empty (rsp_port.stream_empty)
);
